FILE: sv/afv_pkg.sv
// Shared types, widths and constants for the box visibility pipeline.
package afv_pkg;

   localparam int NumRegs  = 8;
   localparam int CsrAddrW = 6;
   localparam int ElemW    = 32;
   localparam int TW       = 67;   // model-space point, Q35.32
   localparam int PW       = 99;   // one projection product, Q51.48
   localparam int CW       = 101;  // clip coordinate, Q53.48
   localparam int InDataW  = 736;
   localparam int OutDataW = 40;

   localparam logic [63:0] ProjReset [NumRegs] = '{
      64'd65536, 64'd0, 64'd281474976710656, 64'd0,
      64'd0, 64'd65536, 64'd0, 64'd281474976710656
   };

   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
   } stage_ctl_type;

   typedef logic signed [ElemW-1:0] elem_type;
   typedef logic signed [TW-1:0]    tpt_type;
   typedef logic signed [CW-1:0]    clip_type;

   function automatic elem_type elem(input logic [63:0] packed_pair, input logic upper);
      return upper ? packed_pair[63:32] : packed_pair[31:0];
   endfunction

endpackage

FILE: sv/aabb_frustum_visibility_test.sv
// Top level of the box-against-frustum visibility pipeline.
// Each transaction carries a model matrix, a box and a tag; one result comes back per
// transaction, in order. A new transaction is accepted every cycle when the output is
// not stalled; the pipeline depth is set by the model multiply, the row sums, the split
// 32-by-67 projection products, their recombination, the clip row sums and the corner
// compare. The pipeline advances whenever the output register is empty or being taken.
// The projection matrix resets to the ProjReset values. The user must write it through
// the csr port only while the block is idle; the block itself does not enforce this.
module aabb_frustum_visibility_test
   import afv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // model_r0c01..model_r3c23, box_min_xy, box_z_min_max, box_max_xy, mesh_tag
   input  logic [InDataW-1:0]  req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // visible, result_tag, zero fill
   output logic [OutDataW-1:0] rsp_tdata,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready
);

   logic          en;
   logic [63:0]   proj [NumRegs];
   logic [63:0]   model [8];
   elem_type      vmin [3], vmax [3];
   stage_ctl_type ctl_in, ctl_m, ctl_p, ctl_o;
   tpt_type       t_min [3], t_max [3];
   clip_type      clip [8][4];
   logic          visible;

   assign en         = !ctl_o.valid || rsp_tready;
   assign req_tready = en;

   for (genvar i = 0; i < 8; i++) begin : g_model
      assign model[i] = req_tdata[64*i +: 64];
   end

   assign vmin[0]      = req_tdata[543:512];
   assign vmin[1]      = req_tdata[575:544];
   assign vmin[2]      = req_tdata[607:576];
   assign vmax[2]      = req_tdata[639:608];
   assign vmax[0]      = req_tdata[671:640];
   assign vmax[1]      = req_tdata[703:672];
   assign ctl_in.valid = req_tvalid;
   assign ctl_in.tag   = req_tdata[735:704];

   afv_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .proj
   );

   afv_model_xform u_model (
      .clock, .reset, .en, .ctl_in, .model, .vmin, .vmax,
      .ctl_out(ctl_m), .t_min, .t_max
   );

   afv_proj_xform u_proj (
      .clock, .reset, .en, .ctl_in(ctl_m), .t_min, .t_max, .proj,
      .ctl_out(ctl_p), .clip
   );

   afv_clip_test u_test (
      .clock, .reset, .en, .ctl_in(ctl_p), .clip, .ctl_out(ctl_o), .visible
   );

   assign rsp_tvalid = ctl_o.valid;
   assign rsp_tdata  = {7'b0, ctl_o.tag, visible};

endmodule

FILE: sv/afv_csr.sv
// Projection matrix register file with an APB-style access port.
module afv_csr
   import afv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready,
   output logic [63:0]         proj [NumRegs]
);

   logic [63:0] proj_ff [NumRegs];
   logic [2:0]  idx;

   assign idx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) proj_ff[i] <= ProjReset[i];
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         proj_ff[idx] <= csr_pwdata;
      end
   end

   assign csr_prdata = proj_ff[idx];
   assign csr_pready = 1'b1;
   assign proj       = proj_ff;

endmodule

FILE: sv/afv_model_xform.sv
// Model transform of the two box corners: products, then row sums.
module afv_model_xform
   import afv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  stage_ctl_type ctl_in,
   input  logic [63:0]   model [8],
   input  elem_type      vmin [3],
   input  elem_type      vmax [3],
   output stage_ctl_type ctl_out,
   output tpt_type       t_min [3],
   output tpt_type       t_max [3]
);

   stage_ctl_type            ctl1_ff, ctl2_ff;
   logic signed [63:0]       prod_ff [2][3][3];
   elem_type                 off_ff [3];
   tpt_type                  tmin_ff [3], tmax_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else if (en) begin
         ctl1_ff.valid <= ctl_in.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
      end
      if (en) begin
         ctl1_ff.tag <= ctl_in.tag;
         ctl2_ff.tag <= ctl1_ff.tag;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         always_ff @(posedge clock) begin
            if (en) begin
               prod_ff[0][r][c] <= elem(model[r*2 + c/2], 1'(c % 2)) * vmin[c];
               prod_ff[1][r][c] <= elem(model[r*2 + c/2], 1'(c % 2)) * vmax[c];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            off_ff[r]  <= elem(model[r*2 + 1], 1'b1);
            tmin_ff[r] <= TW'($signed({off_ff[r], 16'b0})) + TW'(prod_ff[0][r][0])
                        + TW'(prod_ff[0][r][1]) + TW'(prod_ff[0][r][2]);
            tmax_ff[r] <= TW'($signed({off_ff[r], 16'b0})) + TW'(prod_ff[1][r][0])
                        + TW'(prod_ff[1][r][1]) + TW'(prod_ff[1][r][2]);
         end
      end
   end

   assign ctl_out = ctl2_ff;
   assign t_min   = tmin_ff;
   assign t_max   = tmax_ff;

endmodule

FILE: sv/afv_proj_xform.sv
// Projection of the eight corners: split products, recombine, row sums.
module afv_proj_xform
   import afv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  stage_ctl_type ctl_in,
   input  tpt_type       t_min [3],
   input  tpt_type       t_max [3],
   input  logic [63:0]   proj [NumRegs],
   output stage_ctl_type ctl_out,
   output clip_type      clip [8][4]
);

   stage_ctl_type       ctl3_ff, ctl4_ff, ctl5_ff;
   logic signed [64:0]  lo_ff [2][4][3];
   logic signed [66:0]  hi_ff [2][4][3];
   logic signed [PW-1:0] full_ff [2][4][3];
   clip_type            clip_ff [8][4];
   tpt_type             tsel [2][3];

   assign tsel[0] = t_min;
   assign tsel[1] = t_max;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         ctl5_ff.valid <= 1'b0;
      end else if (en) begin
         ctl3_ff.valid <= ctl_in.valid;
         ctl4_ff.valid <= ctl3_ff.valid;
         ctl5_ff.valid <= ctl4_ff.valid;
      end
      if (en) begin
         ctl3_ff.tag <= ctl_in.tag;
         ctl4_ff.tag <= ctl3_ff.tag;
         ctl5_ff.tag <= ctl4_ff.tag;
      end
   end

   for (genvar s = 0; s < 2; s++) begin : g_side
      for (genvar r = 0; r < 4; r++) begin : g_row
         for (genvar c = 0; c < 3; c++) begin : g_col
            always_ff @(posedge clock) begin
               if (en) begin
                  lo_ff[s][r][c] <= elem(proj[r*2 + c/2], 1'(c % 2))
                                  * $signed({1'b0, tsel[s][c][31:0]});
                  hi_ff[s][r][c] <= elem(proj[r*2 + c/2], 1'(c % 2))
                                  * $signed(tsel[s][c][TW-1:32]);
                  full_ff[s][r][c] <= $signed({hi_ff[s][r][c], 32'b0})
                                    + PW'(lo_ff[s][r][c]);
               end
            end
         end
      end
   end

   for (genvar k = 0; k < 8; k++) begin : g_corner
      for (genvar r = 0; r < 4; r++) begin : g_crow
         always_ff @(posedge clock) begin
            if (en) begin
               clip_ff[k][r] <= CW'($signed({elem(proj[r*2 + 1], 1'b1), 32'b0}))
                              + CW'(full_ff[(k >> 2) & 1][r][0])
                              + CW'(full_ff[(k >> 1) & 1][r][1])
                              + CW'(full_ff[k & 1][r][2]);
            end
         end
      end
   end

   assign ctl_out = ctl5_ff;
   assign clip    = clip_ff;

endmodule

FILE: sv/afv_clip_test.sv
// Clip volume test of the eight corners into the result register.
module afv_clip_test
   import afv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  stage_ctl_type ctl_in,
   input  clip_type      clip [8][4],
   output stage_ctl_type ctl_out,
   output logic          visible
);

   stage_ctl_type ctl6_ff;
   logic          visible_ff;
   logic [7:0]    inside_vec;

   for (genvar k = 0; k < 8; k++) begin : g_corner
      clip_type nw;
      assign nw = -clip[k][3];
      assign inside_vec[k] = (nw <= clip[k][0]) && (clip[k][0] <= clip[k][3])
                          && (nw <= clip[k][1]) && (clip[k][1] <= clip[k][3])
                          && (clip[k][2] >= 0) && (clip[k][2] <= clip[k][3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl6_ff.valid <= 1'b0;
      end else if (en) begin
         ctl6_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl6_ff.tag <= ctl_in.tag;
         visible_ff  <= |inside_vec;
      end
   end

   assign ctl_out = ctl6_ff;
   assign visible = visible_ff;

endmodule

FILE: sv/afv_checker.sv
// Port-level checks for the visibility pipeline, bound to the top level.
module afv_checker
   import afv_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [OutDataW-1:0] rsp_tdata,
   input logic                csr_psel,
   input logic                csr_penable,
   input logic                csr_pwrite,
   input logic [CsrAddrW-1:0] csr_paddr,
   input logic [63:0]         csr_pwdata,
   input logic [63:0]         csr_prdata,
   input logic                csr_pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   a_readback: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(csr_psel && csr_penable && csr_pwrite)
      && csr_paddr == $past(csr_paddr) |-> csr_prdata == $past(csr_pwdata))
      else $error("register readback mismatch");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

endmodule

bind aabb_frustum_visibility_test afv_checker u_afv_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata,
   .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
   .csr_prdata, .csr_pready
);

FILE: dv/afv_checker.sv
// Checker: predicts the visible flag and tag of each transaction and compares results.
`timescale 1ns / 1ps
module afv_scoreboard
   import afv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [InDataW-1:0]  req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [OutDataW-1:0] rsp_tdata,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic                csr_pready,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output int                  fail_count,
   output int                  pending_count
);

   logic [63:0] proj_shadow [NumRegs];
   logic [32:0] expected_results [$];

   function automatic logic signed [127:0] coef(input logic [63:0] m [8], input int r,
                                                input int c);
      logic [63:0] pair;
      pair = m[r*2 + c/2];
      return 128'(signed'(c % 2 == 1 ? pair[63:32] : pair[31:0]));
   endfunction

   function automatic logic signed [127:0] row_sum(input logic [63:0] m [8], input int r,
                                                   input logic signed [127:0] v [3],
                                                   input int one_shift);
      logic signed [127:0] acc;
      acc = coef(m, r, 3) <<< one_shift;
      for (int c = 0; c < 3; c++) acc = acc + coef(m, r, c) * v[c];
      return acc;
   endfunction

   function automatic logic box_visible(input logic [InDataW-1:0] d);
      logic [63:0] model [8];
      logic signed [127:0] vmin [3], vmax [3], tmin [3], tmax [3], p [3], clip [4];
      logic hit;
      for (int i = 0; i < 8; i++) model[i] = d[i*64 +: 64];
      vmin[0] = 128'(signed'(d[512 +: 32]));
      vmin[1] = 128'(signed'(d[544 +: 32]));
      vmin[2] = 128'(signed'(d[576 +: 32]));
      vmax[2] = 128'(signed'(d[608 +: 32]));
      vmax[0] = 128'(signed'(d[640 +: 32]));
      vmax[1] = 128'(signed'(d[672 +: 32]));
      for (int r = 0; r < 3; r++) begin
         tmin[r] = row_sum(model, r, vmin, 16);
         tmax[r] = row_sum(model, r, vmax, 16);
      end
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         p[0] = i[2] ? tmax[0] : tmin[0];
         p[1] = i[1] ? tmax[1] : tmin[1];
         p[2] = i[0] ? tmax[2] : tmin[2];
         for (int r = 0; r < 4; r++) clip[r] = row_sum(proj_shadow, r, p, 32);
         if (-clip[3] <= clip[0] && clip[0] <= clip[3] && -clip[3] <= clip[1] &&
             clip[1] <= clip[3] && clip[2] >= 0 && clip[2] <= clip[3])
            hit = 1'b1;
      end
      return hit;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending_count = expected_results.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      logic [32:0] want;
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) proj_shadow[i] = ProjReset[i];
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result tag", rsp_tdata[32:1], 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want[0])
                  report_mismatch("visible", 32'(rsp_tdata[0]), 32'(want[0]));
               if (rsp_tdata[32:1] !== want[32:1])
                  report_mismatch("result_tag", rsp_tdata[32:1], want[32:1]);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back({req_tdata[704 +: 32], box_visible(req_tdata)});
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2:0] == 3'd0 && csr_paddr[CsrAddrW-1:3] < NumRegs)
            proj_shadow[csr_paddr[CsrAddrW-1:3]] = csr_pwdata;
      end
   end

endmodule

FILE: dv/tb_aabb_frustum_visibility_test.sv
// Testbench top: drives box transactions and projection settings, gives the verdict.
`timescale 1ns / 1ps
module tb_aabb_frustum_visibility_test;
   import afv_pkg::*;

   localparam logic [31:0] QOne = 32'h0001_0000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [InDataW-1:0]  req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [OutDataW-1:0] rsp_tdata;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CsrAddrW-1:0] csr_paddr = '0;
   logic [63:0]         csr_pwdata = '0;
   logic [63:0]         csr_prdata;
   logic                csr_pready;
   int                  fail_count;
   int                  pending_count;
   int                  cycle_count = 0;
   bit                  stall_free = 1'b0;

   always #4 clock = ~clock;

   aabb_frustum_visibility_test DUT (.*);

   afv_scoreboard scoreboard_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   always begin : rsp_side
      int idle;
      @(negedge clock);
      idle = stall_free ? 0 : $urandom_range(0, 15);
      if (idle != 0) begin
         rsp_tready <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      rsp_tready <= 1'b1;
      @(posedge clock);
      while (!rsp_tvalid) @(posedge clock);
   end

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   function automatic logic [63:0] pair(input logic [31:0] lo, input logic [31:0] hi);
      return {hi, lo};
   endfunction

   task automatic write_proj(input int idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrW'(idx * 8);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_proj_all(input logic [31:0] e [16]);
      for (int i = 0; i < NumRegs; i++) write_proj(i, pair(e[2*i], e[2*i+1]));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic send_box(input logic [InDataW-1:0] d, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [InDataW-1:0] make_box(input int flavor);
      logic [InDataW-1:0] d;
      logic [31:0] lo, hi;
      d = '0;
      if (flavor == 0) begin
         foreach (d[i]) d[i] = $urandom_range(0, 1);
         return d;
      end
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            d[(r*4 + c)*32 +: 32] = (flavor == 1) ? rand_elem() :
                                    (r == c) ? QOne : ($urandom_range(0, 3) == 0 ?
                                    32'($signed($urandom_range(0, 2 << 16)) - (1 << 16)) :
                                    32'd0);
      for (int k = 0; k < 3; k++) begin
         lo = 32'($signed($urandom_range(0, 3 << 16)) - (2 << 16));
         hi = lo + $urandom_range(0, 2 << 16);
         if ($urandom_range(0, 9) == 0) {lo, hi} = {hi, lo};
         if (flavor == 1) begin
            lo = rand_elem();
            hi = rand_elem();
         end
         case (k)
            0: begin d[512 +: 32] = lo; d[640 +: 32] = hi; end
            1: begin d[544 +: 32] = lo; d[672 +: 32] = hi; end
            default: begin d[576 +: 32] = lo; d[608 +: 32] = hi; end
         endcase
      end
      d[704 +: 32] = $urandom;
      return d;
   endfunction

   initial begin
      logic [InDataW-1:0] d;
      logic [31:0] pm [16];
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: reset projection, extremes and special cases
      send_box('0, 1'b0);
      send_box({InDataW{1'b1}}, 1'b0);
      d = '0;
      for (int i = 0; i < 4; i++) d[(i*5)*32 +: 32] = QOne;
      d[704 +: 32] = 32'hffff_ffff;
      send_box(d, 1'b0);
      d[512 +: 32] = 32'h0000_8000; d[640 +: 32] = 32'hffff_8000;
      send_box(d, 1'b0);
      d[576 +: 32] = 32'h0002_0000; d[608 +: 32] = 32'h0003_0000;
      send_box(d, 1'b0);
      for (int i = 0; i < 16; i++) d[i*32 +: 32] = 32'h8000_0000;
      send_box(d, 1'b0);
      for (int i = 0; i < 16; i++) d[i*32 +: 32] = 32'h7fff_ffff;
      send_box(d, 1'b0);
      for (int i = 0; i < 12; i++) send_box(make_box(i % 3), 1'b1);
      drain();

      // negative w, zero w
      foreach (pm[i]) pm[i] = (i % 5 == 0) ? QOne : 32'd0;
      pm[15] = 32'hffff_0000;
      write_proj_all(pm);
      for (int i = 0; i < 4; i++) send_box(make_box(2), 1'b0);
      drain();
      pm[15] = 32'd0;
      write_proj_all(pm);
      d = '0;
      for (int i = 0; i < 4; i++) d[(i*5)*32 +: 32] = QOne;
      send_box(d, 1'b0);
      send_box(make_box(2), 1'b0);

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         foreach (pm[i]) begin
            case (phase)
               0: pm[i] = 32'h8000_0000;
               1: pm[i] = 32'h7fff_ffff;
               2: pm[i] = $urandom;
               default: pm[i] = (i % 5 == 0) ? QOne + $urandom_range(0, 1 << 16) :
                                32'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
            endcase
         end
         if (phase == 5) write_proj_all('{default: 32'hffff_ffff});
         else write_proj_all(pm);
         stall_free = (phase == 4);
         for (int i = 0; i < 100; i++) begin
            send_box(make_box($urandom_range(0, 9) == 0 ? 0 :
                              ($urandom_range(0, 4) == 0 ? 1 : 2)),
                     phase == 4 || $urandom_range(0, 3) == 0);
         end
      end

      drain();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
